FILE: rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// Greedy box suppression package
// Shared constants for the box suppression block.
// ----------------------------------------------------------------------------
`default_nettype none
package gbs_pkg;
  localparam int unsigned CLASS_BITS = 7;
  localparam int unsigned RANK_BITS = 6;
  localparam int unsigned CFG_IDX_BITS = 8;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_IOU_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLASS_AGNOSTIC = 8'd1;
  localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd29491;
endpackage
`default_nettype wire

FILE: rtl/greedy_box_suppression.sv
// ----------------------------------------------------------------------------
// Greedy box suppression
// Drops a box whose intersection over union with a kept box of its frame and
// class (any class if class-agnostic) exceeds the threshold.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s_axis   in         box item: frame start, geometry, class
// m_axis   out        result item: keep, rank, overflow
// cfg      in         register index and write data
//
// Kept boxes are stored in an on-chip table. For a box, each entry is read, its
// overlap and union are formed, and the shared threshold multiplier and compare
// unit scores it; the next box is taken only once this box is through.
// The scan stops at the first suppressing entry and is skipped at threshold zero.
// Reset empties the table and loads the register reset values.
// A result waits in the output register while the next box is taken; the block
// holds in its last step until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none
module greedy_box_suppression #(
  parameter int unsigned MAX_KEPT = 64,
  parameter int unsigned COORD_BITS = 15
) (
  input  wire logic clk,
  input  wire logic rst,
  // {class_label, box_height, box_width, box_top, box_left}
  input  wire logic [((4*COORD_BITS+5)+7)/8*8-1:0] s_axis_tdata,
  // first_in_frame
  input  wire logic       s_axis_tuser,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  // {table_overflow, kept_rank, keep}
  output logic [7:0]      m_axis_tdata,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [gbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [gbs_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import gbs_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DB = CB - 1;
  localparam int unsigned EB = CB + 1;
  localparam int unsigned AB = 2 * DB;
  localparam int unsigned AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned CW = $clog2(MAX_KEPT + 1);
  localparam int unsigned EW = 2 * EB + EB + EB + CLASS_BITS + AB;
  localparam int unsigned UB = AB + 2;
  localparam int unsigned PB = UB + 16;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]  state;
  logic [15:0] iou_threshold;
  logic        class_agnostic;
  logic [CW-1:0] kept_count;
  logic [CW-1:0] idx;
  logic          sup;

  logic signed [EB-1:0] l, t, r, b;
  logic [CLASS_BITS-1:0] cls;
  logic [AB-1:0] area;

  logic        wr_en;
  logic        out_load;
  logic [EW-1:0] wr_data, rd_data;
  logic [AW-1:0] rd_addr;

  logic [7:0] out_data;

  assign cfg_ready = (state == ST_IDLE);
  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      iou_threshold <= IOU_THRESHOLD_RESET;
      class_agnostic <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IOU_THRESHOLD:  iou_threshold <= cfg_data;
        REG_CLASS_AGNOSTIC: class_agnostic <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Entry fields.
  logic signed [EB-1:0] e_l, e_t, e_r, e_b;
  logic [CLASS_BITS-1:0] e_cls;
  logic [AB-1:0] e_area;
  assign {e_area, e_cls, e_b, e_r, e_t, e_l} = rd_data;
  assign wr_data = {area, cls, b, r, t, l};

  // Overlap and union of the entry just read.
  logic signed [EB-1:0] x1, y1, x2, y2;
  logic signed [EB:0] dx, dy;
  logic [AB+1:0] inter;
  logic signed [UB:0] uni;
  logic match;
  always_comb begin
    x1 = (l > e_l) ? l : e_l;
    y1 = (t > e_t) ? t : e_t;
    x2 = (r < e_r) ? r : e_r;
    y2 = (b < e_b) ? b : e_b;
    dx = {x2[EB-1], x2} - {x1[EB-1], x1};
    dy = {y2[EB-1], y2} - {y1[EB-1], y1};
    if (dx < 0 || dy < 0) inter = '0;
    else inter = (AB+2)'(dx[EB-1:0]) * (AB+2)'(dy[EB-1:0]);
    uni = $signed({2'b00, area}) + $signed({2'b00, e_area}) - $signed({1'b0, inter});
    match = class_agnostic || (e_cls == cls);
  end

  // Shared threshold multiplier and compare unit.
  logic [AB+1:0] inter_q;
  logic signed [UB:0] uni_q;
  logic match_q;
  logic [PB-1:0] lhs, rhs;
  logic hit;
  always_comb begin
    lhs = PB'({inter_q, 16'd0});
    rhs = PB'(iou_threshold) * PB'(uni_q[UB-1:0]);
    hit = match_q && (uni_q > 0) && (lhs > rhs);
  end

  assign rd_addr = idx[AW-1:0];
  assign out_load = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign wr_en = out_load && !sup && (kept_count < CW'(MAX_KEPT));

  gbs_ram #(.WIDTH(EW), .DEPTH(MAX_KEPT)) u_table (
    .clk(clk), .wr_en(wr_en), .wr_addr(kept_count[AW-1:0]), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      kept_count <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            if (s_axis_tuser) kept_count <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (iou_threshold == 16'd0 || idx >= kept_count) state <= ST_DONE;
          else state <= ST_CALC;
        end
        ST_CALC: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          state <= hit ? ST_DONE : ST_READ;
        end
        ST_DONE: begin
          if (out_load) begin
            if (wr_en) kept_count <= kept_count + 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        idx <= '0;
        sup <= 1'b0;
        l <= EB'($signed(s_axis_tdata[CB-1:0]));
        t <= EB'($signed(s_axis_tdata[2*CB-1:CB]));
        r <= EB'($signed(s_axis_tdata[CB-1:0])) + EB'(s_axis_tdata[2*CB+DB-1:2*CB]);
        b <= EB'($signed(s_axis_tdata[2*CB-1:CB])) + EB'(s_axis_tdata[2*CB+2*DB-1:2*CB+DB]);
        area <= AB'(s_axis_tdata[2*CB+DB-1:2*CB]) * AB'(s_axis_tdata[2*CB+2*DB-1:2*CB+DB]);
        cls <= s_axis_tdata[2*CB+2*DB+CLASS_BITS-1:2*CB+2*DB];
      end
      ST_CALC: begin
        inter_q <= inter;
        uni_q <= uni;
        match_q <= match;
      end
      ST_CMP: begin
        idx <= idx + 1'b1;
        if (hit) sup <= 1'b1;
      end
      ST_DONE: begin
        if (out_load) m_axis_tdata <= out_data;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data = '0;
    if (!sup) begin
      out_data[0] = 1'b1;
      out_data[RANK_BITS:1] = (kept_count > CW'(63)) ? RANK_BITS'(63)
                                                     : RANK_BITS'(kept_count);
      out_data[RANK_BITS+1] = (kept_count >= CW'(MAX_KEPT));
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= CW'(MAX_KEPT)) else $error("kept count beyond table depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> m_axis_tvalid) else $error("result not presented");
endmodule
`default_nettype wire

FILE: rtl/gbs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module gbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire
